### hw/rtl/jqc_pkg.sv
package jqc_pkg;

	localparam int DEPTH      = 16;
	localparam int TAG_BITS   = 32;
	localparam int IDX_BITS   = $clog2(DEPTH);
	localparam int CNT_BITS   = IDX_BITS + 1;
	localparam int IN_TAG_BITS = 32;
	localparam int PAGE_BITS  = 8;
	localparam int OCC_BITS   = 4;
	localparam int ENT_BITS   = TAG_BITS + PAGE_BITS;
	localparam logic [PAGE_BITS-1:0] MAX_PAGES_RST = 8'd50;

	typedef logic [IDX_BITS-1:0]  idx_t;
	typedef logic [TAG_BITS-1:0]  tag_t;
	typedef logic [PAGE_BITS-1:0] pages_t;

	typedef enum logic [1:0] {
		CMD_ENQ    = 2'd0,
		CMD_DEQ    = 2'd1,
		CMD_CANCEL = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_PAGES    = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic    rdy;
		logic    enq;
		logic    clr;
		logic    rd_head;
		logic    pop;
		logic    step;
		logic    mv;
		logic    drop;
		logic    res_en;
		logic    res_data;
		status_t res_st;
		logic    emit;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic in_valid;
		cmd_t op;
		logic empty;
		logic full;
		logic over;
		logic hit;
		logic last;
		logic out_free;
	} sts_t;

	function automatic idx_t ring_next(idx_t i);
		return (i == IDX_BITS'(DEPTH - 1)) ? '0 : i + IDX_BITS'(1);
	endfunction

	function automatic idx_t ring_prev(idx_t i);
		return (i == '0) ? IDX_BITS'(DEPTH - 1) : i - IDX_BITS'(1);
	endfunction

	function automatic logic [OCC_BITS-1:0] held(idx_t h, idx_t t);
		logic [CNT_BITS-1:0] d;
		if (t >= h)
			d = {1'b0, t} - {1'b0, h};
		else
			d = {1'b0, t} + CNT_BITS'(DEPTH) - {1'b0, h};
		return OCC_BITS'(d);
	endfunction

	function automatic tag_t tag_in(logic [IN_TAG_BITS-1:0] t);
		logic [63:0] w;
		w = 64'(t);
		return w[TAG_BITS-1:0];
	endfunction

	function automatic logic [IN_TAG_BITS-1:0] tag_out(tag_t g);
		logic [63:0] w;
		w = 64'(g);
		return w[IN_TAG_BITS-1:0];
	endfunction

endpackage

### hw/rtl/jqc_job_if.sv
interface jqc_job_if import jqc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	cmd_t                   cmd;
	logic [IN_TAG_BITS-1:0] job_tag;
	pages_t                 page_count;

	modport source (output valid, cmd, job_tag, page_count, input ready);
	modport sink   (input valid, cmd, job_tag, page_count, output ready);
endinterface

### hw/rtl/jqc_res_if.sv
interface jqc_res_if import jqc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	status_t                status;
	logic [IN_TAG_BITS-1:0] out_tag;
	pages_t                 out_pages;
	logic [OCC_BITS-1:0]    occupancy;

	modport source (output valid, status, out_tag, out_pages, occupancy, input ready);
	modport sink   (input valid, status, out_tag, out_pages, occupancy, output ready);
endinterface

### hw/rtl/jqc_ram.sv
module jqc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/jqc_ctrl.sv
module jqc_ctrl import jqc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  sts_t sts,
	output ctl_t ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DEQ,
		S_SCAN,
		S_SHIFT,
		S_FINISH
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		ctl     = '0;
		ctl.res_st = ST_OK;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				ctl.rdy = 1'b1;
				if (sts.in_valid)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_FINISH;
				unique case (sts.op)
					CMD_ENQ: begin
						ctl.res_en = 1'b1;
						if (sts.full)
							ctl.res_st = ST_FULL;
						else if (sts.over)
							ctl.res_st = ST_PAGES;
						else
							ctl.enq = 1'b1;
					end
					CMD_DEQ, CMD_CANCEL: begin
						if (sts.empty) begin
							ctl.res_en = 1'b1;
							ctl.res_st = ST_EMPTY;
						end else begin
							ctl.rd_head = 1'b1;
							state_d = (sts.op == CMD_DEQ) ? S_DEQ : S_SCAN;
						end
					end
					CMD_CLEAR: begin
						ctl.res_en = 1'b1;
						ctl.clr    = 1'b1;
					end
					default: ;
				endcase
			end
			S_DEQ: begin
				ctl.res_en   = 1'b1;
				ctl.res_data = 1'b1;
				ctl.pop      = 1'b1;
				state_d      = S_FINISH;
			end
			S_SCAN: begin
				if (sts.hit) begin
					ctl.res_en   = 1'b1;
					ctl.res_data = 1'b1;
					if (sts.last) begin
						ctl.drop = 1'b1;
						state_d  = S_FINISH;
					end else begin
						ctl.step = 1'b1;
						state_d  = S_SHIFT;
					end
				end else if (sts.last) begin
					ctl.res_en = 1'b1;
					ctl.res_st = ST_NOTFOUND;
					state_d    = S_FINISH;
				end else begin
					ctl.step = 1'b1;
				end
			end
			S_SHIFT: begin
				ctl.mv = 1'b1;
				if (sts.last) begin
					ctl.drop = 1'b1;
					state_d  = S_FINISH;
				end else begin
					ctl.step = 1'b1;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

### hw/rtl/jqc_datapath.sv
module jqc_datapath import jqc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  pages_t         cfg_wdata,
	jqc_job_if.sink        job,
	jqc_res_if.source      res,
	input  ctl_t           ctl,
	output sts_t           sts
);

	idx_t    head_q, tail_q, cmp_q;
	pages_t  max_pages_q;
	logic    out_valid_q;
	cmd_t    op_q;
	tag_t    tag_q;
	pages_t  pages_q;
	status_t res_st_q;
	tag_t    res_tag_q;
	pages_t  res_pages_q;
	status_t out_st_q;
	tag_t    out_tag_q;
	pages_t  out_pages_q;
	logic [OCC_BITS-1:0] out_occ_q;

	logic                we;
	idx_t                waddr, raddr;
	logic [ENT_BITS-1:0] wdata, rdata;
	tag_t                rd_tag;
	pages_t              rd_pages;

	assign rd_tag   = rdata[ENT_BITS-1:PAGE_BITS];
	assign rd_pages = rdata[PAGE_BITS-1:0];

	// one write port: new entry at the tail, or a shifted entry one slot back
	assign we    = ctl.enq | ctl.mv;
	assign waddr = ctl.mv ? ring_prev(cmp_q) : tail_q;
	assign wdata = ctl.mv ? rdata : {tag_q, pages_q};
	assign raddr = ctl.rd_head ? head_q : ring_next(cmp_q);

	jqc_ram #(
		.WIDTH(ENT_BITS),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			max_pages_q <= MAX_PAGES_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				max_pages_q <= cfg_wdata;
			if (ctl.clr) begin
				head_q <= '0;
				tail_q <= '0;
			end else begin
				if (ctl.enq)
					tail_q <= ring_next(tail_q);
				else if (ctl.drop)
					tail_q <= ring_prev(tail_q);
				if (ctl.pop)
					head_q <= ring_next(head_q);
			end
			if (ctl.emit)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job.valid && ctl.rdy) begin
			op_q    <= job.cmd;
			tag_q   <= tag_in(job.job_tag);
			pages_q <= job.page_count;
		end
		if (ctl.rd_head)
			cmp_q <= head_q;
		else if (ctl.step)
			cmp_q <= ring_next(cmp_q);
		if (ctl.res_en) begin
			res_st_q    <= ctl.res_st;
			res_tag_q   <= ctl.res_data ? rd_tag : '0;
			res_pages_q <= ctl.res_data ? rd_pages : '0;
		end
		if (ctl.emit) begin
			out_st_q    <= res_st_q;
			out_tag_q   <= res_tag_q;
			out_pages_q <= res_pages_q;
			out_occ_q   <= held(head_q, tail_q);
		end
	end

	assign job.ready     = ctl.rdy;
	assign res.valid     = out_valid_q;
	assign res.status    = out_st_q;
	assign res.out_tag   = tag_out(out_tag_q);
	assign res.out_pages = out_pages_q;
	assign res.occupancy = out_occ_q;

	assign sts.in_valid = job.valid;
	assign sts.op       = op_q;
	assign sts.empty    = (head_q == tail_q);
	assign sts.full     = (ring_next(tail_q) == head_q);
	assign sts.over     = (pages_q > max_pages_q);
	assign sts.hit      = (rd_tag == tag_q);
	assign sts.last     = (ring_next(cmp_q) == tail_q);
	assign sts.out_free = !out_valid_q || res.ready;

`ifndef SYNTHESIS
	a_enq_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.enq |-> (!sts.full && !sts.over))
		else $error("enqueue written into a full queue or with too many pages");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> sts.out_free)
		else $error("result loaded over an untaken result");
	a_mv_ring: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.mv |-> (!sts.empty && (cmp_q != tail_q)))
		else $error("shift outside the held entries");
	a_drop_held: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.drop |-> !sts.empty)
		else $error("tail stepped back on an empty queue");
`endif

endmodule

### hw/rtl/job_queue_with_cancel.sv
// command flow: the exec state decodes, then the finish state loads the output register;
// dequeue reads the head first, cancel scans each held job once and shifts those after a hit
// one command in flight; the next is taken once its result sits in the output register,
// and a result waits in the finish state until the previous one has left that register
// reset: pointers to zero, max_pages to 50, output empty; store contents left as they are
module job_queue_with_cancel import jqc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  pages_t    cfg_wdata,
	jqc_job_if.sink   job,
	jqc_res_if.source res
);

	// command and status bundles between the sequencer and the datapath
	ctl_t ctl;
	sts_t sts;

	// sequencer: decode, head read, cancel scan, shift pass, result hand-off
	jqc_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.sts   (sts),
		.ctl   (ctl)
	);

	// datapath: ring pointers, entry store, compare, result and output registers
	jqc_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.job      (job),
		.res      (res),
		.ctl      (ctl),
		.sts      (sts)
	);

endmodule
